// ===== rtl/aes_pkg.sv =====
package aes_pkg;

  // Byte codes that steer the parser.
  localparam logic [7:0] ByteEsc       = 8'h1b;
  localparam logic [7:0] ByteBel       = 8'h07;
  localparam logic [7:0] ByteTab       = 8'h09;
  localparam logic [7:0] ByteNewline   = 8'h0a;
  localparam logic [7:0] ByteSpace     = 8'h20;
  localparam logic [7:0] ByteDel       = 8'h7f;
  localparam logic [7:0] ByteC2        = 8'hc2;
  localparam logic [7:0] ByteC1Lo      = 8'h80;
  localparam logic [7:0] ByteC1Hi      = 8'h9f;
  localparam logic [7:0] ByteFinalLo   = 8'h40;
  localparam logic [7:0] ByteFinalHi   = 8'h7e;
  localparam logic [7:0] ByteCsiIntro  = 8'h5b;
  localparam logic [7:0] ByteOsc       = 8'h5d;
  localparam logic [7:0] ByteDcs       = 8'h50;
  localparam logic [7:0] ByteSos       = 8'h58;
  localparam logic [7:0] BytePm        = 8'h5e;
  localparam logic [7:0] ByteApc       = 8'h5f;
  localparam logic [7:0] ByteBackslash = 8'h5c;

  typedef enum logic [2:0] {
    ModePlain  = 3'd0,
    ModeEsc    = 3'd1,
    ModeCsi    = 3'd2,
    ModeStr    = 3'd3,
    ModeStrEsc = 3'd4
  } mode_e;

  typedef struct packed {
    mode_e mode;
    logic  held;
  } par_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       text_end;
  } res_t;

  typedef struct packed {
    par_state_t state;
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } par_out_t;

endpackage

// ===== rtl/aes_parser.sv =====
module aes_parser (
  input  aes_pkg::par_state_t state_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output aes_pkg::par_out_t   out_o
);

  logic       kept;
  logic       c2_out;
  logic       proceed;
  logic       byte_out;
  logic       is_c1;
  logic [1:0] count;
  aes_pkg::par_state_t nxt;
  aes_pkg::res_t r0;
  aes_pkg::res_t r1;

  assign is_c1 = byte_i inside {[aes_pkg::ByteC1Lo : aes_pkg::ByteC1Hi]};

  always_comb begin
    kept = 1'b1;
    if ((byte_i < aes_pkg::ByteSpace) && (byte_i != aes_pkg::ByteNewline) &&
        (byte_i != aes_pkg::ByteTab)) begin
      kept = 1'b0;
    end
    if (byte_i == aes_pkg::ByteDel || is_c1) begin
      kept = 1'b0;
    end
  end

  // Mode transitions and the kept bytes of one input item.
  always_comb begin
    nxt      = state_i;
    c2_out   = 1'b0;
    proceed  = 1'b0;
    byte_out = 1'b0;
    case (state_i.mode)
      aes_pkg::ModeEsc: begin
        if (byte_i == aes_pkg::ByteCsiIntro) begin
          nxt.mode = aes_pkg::ModeCsi;
        end else if (byte_i inside {aes_pkg::ByteOsc, aes_pkg::ByteDcs, aes_pkg::ByteSos,
                                    aes_pkg::BytePm, aes_pkg::ByteApc}) begin
          nxt.mode = aes_pkg::ModeStr;
        end else begin
          nxt.mode = aes_pkg::ModePlain;
        end
      end
      aes_pkg::ModeCsi: begin
        if (byte_i inside {[aes_pkg::ByteFinalLo : aes_pkg::ByteFinalHi]}) begin
          nxt.mode = aes_pkg::ModePlain;
        end
      end
      aes_pkg::ModeStr, aes_pkg::ModeStrEsc: begin
        if (state_i.mode == aes_pkg::ModeStrEsc && byte_i == aes_pkg::ByteBackslash) begin
          nxt.mode = aes_pkg::ModePlain;
        end else if (byte_i == aes_pkg::ByteBel) begin
          nxt.mode = aes_pkg::ModePlain;
        end else if (byte_i == aes_pkg::ByteEsc) begin
          nxt.mode = aes_pkg::ModeStrEsc;
        end else begin
          nxt.mode = aes_pkg::ModeStr;
        end
      end
      default: begin
        nxt.mode = aes_pkg::ModePlain;
        nxt.held = 1'b0;
        c2_out   = state_i.held && !is_c1;
        proceed  = !state_i.held || c2_out;
        if (proceed) begin
          if (byte_i == aes_pkg::ByteEsc) begin
            nxt.mode = aes_pkg::ModeEsc;
          end else if (byte_i == aes_pkg::ByteC2 && !last_i) begin
            nxt.held = 1'b1;
          end else if (kept) begin
            byte_out = 1'b1;
          end
        end
      end
    endcase
  end

  // Pack the results; the end of a text always yields at least one result.
  always_comb begin
    r0 = '0;
    r1 = '0;
    count = 2'd0;
    if (c2_out) begin
      r0.out_byte = aes_pkg::ByteC2;
      r0.has_byte = 1'b1;
      count = 2'd1;
      if (byte_out) begin
        r1.out_byte = byte_i;
        r1.has_byte = 1'b1;
        count = 2'd2;
      end
    end else if (byte_out) begin
      r0.out_byte = byte_i;
      r0.has_byte = 1'b1;
      count = 2'd1;
    end
    if (last_i && count == 2'd0) begin
      count = 2'd1;
    end
    if (count == 2'd2) begin
      r1.run_last = 1'b1;
      r1.text_end = last_i;
    end else begin
      r0.run_last = 1'b1;
      r0.text_end = last_i;
    end
  end

  always_comb begin
    out_o.state = nxt;
    if (last_i) begin
      out_o.state.mode = aes_pkg::ModePlain;
      out_o.state.held = 1'b0;
    end
    out_o.count = count;
    out_o.res0  = r0;
    out_o.res1  = r1;
  end

endmodule

// ===== rtl/ansi_escape_stripper_unit.sv =====
// Byte-wide filter that strips terminal escape and control sequences from a
// text and passes on the printable bytes. One byte enters per item on the
// slave side; tlast marks the final byte of a text. Dropped are ESC with the
// byte after it, CSI sequences through their final byte, OSC/DCS/SOS/PM/APC
// strings through BEL or ESC backslash, UTF-8 C1 pairs, C0 controls other
// than newline and tab, DEL and raw 0x80..0x9F. A 0xC2 is held back until the
// next byte decides whether it opens a C1 pair, so one input item can give
// two output items (the released 0xC2 and the new byte); a dropped byte gives
// none, except that the final byte of a text always gives at least one, with
// has_byte low when it carries no byte. The block accepts one item per clock
// while the output is ready; the result buffer drains one item per clock
// while m_axis_tready is high, so an input item with two results holds the
// input until both drain. Path: input register, then result register.
module ansi_escape_stripper_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // text_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o,   // run_last
  output logic [1:0] m_axis_tuser_o    // [0] has_byte, [1] text_end
);

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Parser state, updated when the registered item moves on.
  aes_pkg::par_state_t state_q;
  aes_pkg::par_out_t   par;

  // Result buffer: up to two results, head in res0_q.
  aes_pkg::res_t res0_q, res0_d;
  aes_pkg::res_t res1_q, res1_d;
  logic [1:0]    cnt_q, cnt_d;

  logic pop;
  logic free;
  logic advance;
  logic load;

  aes_parser u_parser (
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .out_o   (par)
  );

  assign pop  = (cnt_q != 2'd0) && m_axis_tready_i;
  // The buffer can take a fresh group when it is empty after this cycle's pop.
  assign free = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
  // An item that gives no result moves on regardless of the buffer.
  assign advance = in_valid_q && ((par.count == 2'd0) || free);
  assign load    = advance && (par.count != 2'd0);

  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode <= aes_pkg::ModePlain;
      state_q.held <= 1'b0;
    end else if (advance) begin
      state_q <= par.state;
    end
  end

  always_comb begin
    res0_d = res0_q;
    res1_d = res1_q;
    cnt_d  = cnt_q;
    if (load) begin
      res0_d = par.res0;
      res1_d = par.res1;
      cnt_d  = par.count;
    end else if (pop) begin
      res0_d = res1_q;
      cnt_d  = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res0_q <= res0_d;
    res1_q <= res1_d;
  end

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = res0_q.out_byte;
  assign m_axis_tlast_o  = res0_q.run_last;
  assign m_axis_tuser_o  = {res0_q.text_end, res0_q.has_byte};

endmodule
